>>> hw/rtl/lav_pkg.sv
// Shared types and constants for the look-at view matrix block.
package lav_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int REG_IDX_W         = 2;

  localparam logic [REG_IDX_W-1:0] REG_UP_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_UP_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_UP_Z = 2'd2;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } camera_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               degenerate;
    logic               last_row;
  } row_t;

  // Classified camera update handed from front to back.
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][32:0] mag;
    logic [2:0]       neg;
    logic             degen;
  } cmd_t;

endpackage

>>> hw/rtl/lav_fifo.sv
// Small register FIFO used between front and back and on the result side.
module lav_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/lav_front.sv
// Front end: takes camera updates, forms eye minus target and flags eye == target.
module lav_front (
  input  lav_pkg::camera_t camera,
  input  logic             push,
  output logic             full,
  input  logic             cmd_full,
  output logic             cmd_push,
  output lav_pkg::cmd_t    cmd
);
  import lav_pkg::*;

  logic signed [2:0][32:0] diff;

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

  always_comb begin
    diff[0] = 33'(camera.eye_x) - 33'(camera.target_x);
    diff[1] = 33'(camera.eye_y) - 33'(camera.target_y);
    diff[2] = 33'(camera.eye_z) - 33'(camera.target_z);
    cmd.eye[0] = camera.eye_x;
    cmd.eye[1] = camera.eye_y;
    cmd.eye[2] = camera.eye_z;
    for (int i = 0; i < 3; i++) begin
      cmd.neg[i] = diff[i][32];
      cmd.mag[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
    end
    cmd.degen = (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
  end

endmodule

>>> hw/rtl/lav_back.sv
// Back end: normalize, square root, divide, cross and dot products, row emission.
module lav_back #(
  parameter int FRACTION_BITS = lav_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0][31:0]  up,
  input  lav_pkg::cmd_t     cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output lav_pkg::row_t     res_row
);
  import lav_pkg::*;

  localparam int NW = 31 + FRACTION_BITS;     // numerator width
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRACTION_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_NORM  = 8'b00000010,
    S_SQ    = 8'b00000100,
    S_SQRT  = 8'b00001000,
    S_DLOAD = 8'b00010000,
    S_DIV   = 8'b00100000,
    S_MUL   = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  state_t             state;
  logic [2:0][31:0]   eye;
  logic [2:0][32:0]   mag;
  logic [2:0]         neg;
  logic               degen;
  logic [1:0]         k;
  logic [61:0]        sum;
  logic [62:0]        sq_x;
  logic [62:0]        sq_root;
  logic [62:0]        sq_bit;
  logic [31:0]        n;
  logic [NW-1:0]      num;
  logic [NW-1:0]      quo;
  logic [31:0]        rem;
  logic [CW-1:0]      cnt;
  logic signed [31:0] fwd [0:2];
  logic signed [31:0] axis [0:8];   // r 0..2, u 3..5, dots 6..8
  logic [4:0]         op;
  logic [1:0]         phase;
  logic signed [63:0] prod;
  logic signed [63:0] qv;
  logic signed [63:0] acc;
  logic [1:0]         row;

  // combinational helpers
  logic [32:0]        mx;
  logic [29:0]        mag_k;
  logic [59:0]        sq;
  logic [63:0]        trial;
  logic [32:0]        rem_sh;
  logic               qbit;
  logic [NW-1:0]      quo_fin;
  logic signed [63:0] fq;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic               op_sub;
  logic               op_first;
  logic               op_last;
  logic [3:0]         op_dest;
  logic signed [63:0] acc_n;

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    case (k)
      2'd0:    mag_k = mag[0][29:0];
      2'd1:    mag_k = mag[1][29:0];
      default: mag_k = mag[2][29:0];
    endcase
    sq      = mag_k * mag_k;
    trial   = {1'b0, sq_root} + {1'b0, sq_bit};
    rem_sh  = {rem, num[NW-1]};
    qbit    = (rem_sh >= {1'b0, n});
    quo_fin = {quo[NW-2:0], qbit};
    fq      = 64'(quo_fin);
    if (neg[k]) fq = -fq;
  end

  // product schedule: r = up x f, u = f x r, then the three negated dots
  always_comb begin
    opa = '0; opb = '0; op_sub = 1'b0; op_first = 1'b0; op_last = 1'b0; op_dest = '0;
    case (op)
      5'd0:  begin opa = up[1];   opb = fwd[2];  op_first = 1'b1; end
      5'd1:  begin opa = up[2];   opb = fwd[1];  op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd0; end
      5'd2:  begin opa = up[2];   opb = fwd[0];  op_first = 1'b1; end
      5'd3:  begin opa = up[0];   opb = fwd[2];  op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd1; end
      5'd4:  begin opa = up[0];   opb = fwd[1];  op_first = 1'b1; end
      5'd5:  begin opa = up[1];   opb = fwd[0];  op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd2; end
      5'd6:  begin opa = fwd[1];  opb = axis[2]; op_first = 1'b1; end
      5'd7:  begin opa = fwd[2];  opb = axis[1]; op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd3; end
      5'd8:  begin opa = fwd[2];  opb = axis[0]; op_first = 1'b1; end
      5'd9:  begin opa = fwd[0];  opb = axis[2]; op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd4; end
      5'd10: begin opa = fwd[0];  opb = axis[1]; op_first = 1'b1; end
      5'd11: begin opa = fwd[1];  opb = axis[0]; op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd5; end
      5'd12: begin opa = axis[0]; opb = eye[0];  op_sub = 1'b1; op_first = 1'b1; end
      5'd13: begin opa = axis[1]; opb = eye[1];  op_sub = 1'b1; end
      5'd14: begin opa = axis[2]; opb = eye[2];  op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd6; end
      5'd15: begin opa = axis[3]; opb = eye[0];  op_sub = 1'b1; op_first = 1'b1; end
      5'd16: begin opa = axis[4]; opb = eye[1];  op_sub = 1'b1; end
      5'd17: begin opa = axis[5]; opb = eye[2];  op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd7; end
      5'd18: begin opa = fwd[0];  opb = eye[0];  op_sub = 1'b1; op_first = 1'b1; end
      5'd19: begin opa = fwd[1];  opb = eye[1];  op_sub = 1'b1; end
      5'd20: begin opa = fwd[2];  opb = eye[2];  op_sub = 1'b1; op_last = 1'b1; op_dest = 4'd8; end
      default: ;
    endcase
    acc_n = (op_first ? 64'sd0 : acc) + (op_sub ? -qv : qv);
  end

  // row assembly
  always_comb begin
    res_row.row_index  = row;
    res_row.degenerate = degen;
    res_row.last_row   = (row == 2'd3);
    res_row.col0 = '0; res_row.col1 = '0; res_row.col2 = '0; res_row.col3 = '0;
    case (row)
      2'd0: if (!degen) begin
        res_row.col0 = axis[0]; res_row.col1 = axis[1];
        res_row.col2 = axis[2]; res_row.col3 = axis[6];
      end
      2'd1: if (!degen) begin
        res_row.col0 = axis[3]; res_row.col1 = axis[4];
        res_row.col2 = axis[5]; res_row.col3 = axis[7];
      end
      2'd2: if (!degen) begin
        res_row.col0 = fwd[0]; res_row.col1 = fwd[1];
        res_row.col2 = fwd[2]; res_row.col3 = axis[8];
      end
      default: res_row.col3 = ONE;
    endcase
  end

  assign cmd_pop  = (state == S_IDLE) && !cmd_empty;
  assign res_push = (state == S_EMIT) && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      op    <= '0;
      phase <= '0;
      row   <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: if (!cmd_empty) begin
          row   <= '0;
          state <= cmd.degen ? S_EMIT : S_NORM;
        end
        S_NORM: begin
          if (mx >= 33'd1 << 30) begin
          end else if (mx < 33'd1 << 29) begin
          end else begin
            k     <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (k == 2'd2) begin
            state <= S_SQRT;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_SQRT: if (sq_bit[0]) begin
          k     <= '0;
          state <= S_DLOAD;
        end
        S_DLOAD: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CW'(NW - 1)) begin
            if (k == 2'd2) begin
              op    <= '0;
              phase <= '0;
              state <= S_MUL;
            end else begin
              k     <= k + 1'b1;
              state <= S_DLOAD;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MUL: begin
          if (phase == 2'd2) begin
            phase <= '0;
            if (op == 5'd20) begin
              row   <= '0;
              state <= S_EMIT;
            end else begin
              op <= op + 1'b1;
            end
          end else begin
            phase <= phase + 1'b1;
          end
        end
        S_EMIT: if (!res_full) begin
          row <= row + 1'b1;
          if (row == 2'd3) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        eye   <= cmd.eye;
        mag   <= cmd.mag;
        neg   <= cmd.neg;
        degen <= cmd.degen;
        sum   <= '0;
      end
      S_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (mx >= 33'd1 << 30) mag[i] <= mag[i] >> 1;
          else if (mx < 33'd1 << 29) mag[i] <= mag[i] << 1;
        end
      end
      S_SQ: begin
        sum <= sum + 62'(sq);
        if (k == 2'd2) begin
          sq_x    <= 63'(sum + 62'(sq));
          sq_root <= '0;
          sq_bit  <= 63'd1 << 62;
        end
      end
      S_SQRT: begin
        if ({1'b0, sq_x} >= trial) begin
          sq_x    <= sq_x - trial[62:0];
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit[0]) begin
          if ({1'b0, sq_x} >= trial) n <= 32'((sq_root >> 1) + sq_bit);
          else                       n <= (sq_root[32:1] == '0) ? 32'd1 : sq_root[32:1];
        end
      end
      S_DLOAD: begin
        num <= (NW'(mag_k) << FRACTION_BITS) + NW'(n >> 1);
        rem <= '0;
        quo <= '0;
      end
      S_DIV: begin
        rem <= qbit ? 32'(rem_sh - {1'b0, n}) : rem_sh[31:0];
        quo <= quo_fin;
        num <= num << 1;
        if (cnt == CW'(NW - 1)) fwd[k] <= sat32(fq);
      end
      S_MUL: begin
        case (phase)
          2'd0: prod <= opa * opb;
          2'd1: qv   <= (prod + (prod[63] ? HALF - 64'sd1 : HALF)) >>> FRACTION_BITS;
          default: begin
            acc <= acc_n;
            if (op_last) axis[op_dest] <= sat32(acc_n);
          end
        endcase
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/look_at_view_matrix.sv
// Look-at view matrix: eye/target in, four matrix rows out per transaction.
// From accept to first row the back end runs a normalize loop, a serial square root,
// a divider for each axis (Q16.16 by default) and the shared multiplier for the products.
// The back end handles one update at a time; a two-deep command queue takes new ones meanwhile.
// An update with eye == target skips the arithmetic and emits its rows directly.
// Reset (synchronous, rst high) empties both queues and loads up = (0, ONE, 0).
module look_at_view_matrix #(
  parameter int FRACTION_BITS = lav_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  lav_pkg::camera_t                camera,
  output logic                            empty,
  input  logic                            pop,
  output lav_pkg::row_t                   row,
  input  logic                            wr_en,
  input  logic [lav_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [31:0]                     wr_data
);
  import lav_pkg::*;

  logic [2:0][31:0] up;
  cmd_t             cmd_in;
  cmd_t             cmd_out;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  row_t             res_row;
  logic             res_push;
  logic             res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      up[0] <= '0;
      up[1] <= 32'd1 << FRACTION_BITS;
      up[2] <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_UP_X: up[0] <= wr_data;
        REG_UP_Y: up[1] <= wr_data;
        REG_UP_Z: up[2] <= wr_data;
        default: ;
      endcase
    end
  end

  lav_front u_front (
    .camera   (camera),
    .push     (push),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  lav_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  lav_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .up        (up),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_row   (res_row)
  );

  lav_fifo #(.WIDTH($bits(row_t)), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_row),
    .full  (res_full),
    .pop   (pop),
    .rdata (row),
    .empty (empty)
  );

endmodule

>>> hw/rtl/lav_checker.sv
// Port-level checks for the look-at view matrix, bound to the top level.
module lav_checker (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input lav_pkg::row_t    row
);
  import lav_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(row)))
    else $error("waiting row changed");

  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (row.last_row == (row.row_index == 2'd3)))
    else $error("last_row flag disagrees with row index");

  a_row3: assert property (@(posedge clk) disable iff (rst)
    (!empty && row.row_index == 2'd3) |->
      (row.col0 == '0 && row.col1 == '0 && row.col2 == '0))
    else $error("fourth row axis not zero");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    (!empty && row.degenerate && row.row_index != 2'd3) |->
      (row.col0 == '0 && row.col1 == '0 && row.col2 == '0 && row.col3 == '0))
    else $error("degenerate row not zero");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .row   (row)
);
